>>> rtl/ckc_pkg.sv
// Shared types, constants and byte/digit helper functions of the keyed
// base-62 chained byte cipher. No dependencies.
package ckc_pkg;

    localparam int KEY_DEPTH_DFLT = 64;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPW            = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW            = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_DATA = 1'b1;

    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    localparam logic CFG_MODE       = 1'b0;
    localparam logic CFG_KEY_LENGTH = 1'b1;

    localparam logic [7:0] CHAR_X    = 8'h58;
    localparam logic [7:0] CHAR_D    = 8'h44;
    localparam logic [5:0] ESC_BASE  = 6'd57;
    localparam logic [7:0] DEC_BIAS  = 8'd186;
    localparam logic [1:0] TAG_DONE  = 2'd2;

    typedef enum logic [2:0] {
        B_IDLE,
        B_TAG_X,
        B_TAG_D,
        B_DIG,
        B_DIG2
    } back_state_t;

    typedef struct packed {
        logic       cls_nz;
        logic [2:0] cls;
        logic [5:0] val;
    } split_t;

    typedef struct packed {
        logic [5:0] digit;
        logic       bad;
    } char_t;

    typedef struct packed {
        logic       op;
        logic       first;
        logic [5:0] key_index;
        logic [7:0] key_byte;
        logic [7:0] data_byte;
        logic [2:0] cls;
        logic [5:0] val;
        logic       bad;
    } entry_t;

    function automatic logic [5:0] mod62(input logic [7:0] x);
        logic [5:0] r;
        if (x >= 8'd248)
            r = 6'(x - 8'd248);
        else if (x >= 8'd186)
            r = 6'(x - 8'd186);
        else if (x >= 8'd124)
            r = 6'(x - 8'd124);
        else if (x >= 8'd62)
            r = 6'(x - 8'd62);
        else
            r = 6'(x);
        return r;
    endfunction

    function automatic logic [7:0] to_char(input logic [5:0] d);
        logic [7:0] r;
        if (d < 6'd10)
            r = 8'(d) + 8'd48;
        else if (d < 6'd36)
            r = 8'(d) + 8'd55;
        else
            r = 8'(d) + 8'd61;
        return r;
    endfunction

    function automatic char_t from_char(input logic [7:0] c);
        char_t r;
        r.bad = 1'b0;
        if (c >= 8'd48 && c <= 8'd57)
            r.digit = 6'(c - 8'd48);
        else if (c >= 8'd65 && c <= 8'd90)
            r.digit = 6'(c - 8'd55);
        else if (c >= 8'd97 && c <= 8'd122)
            r.digit = 6'(c - 8'd61);
        else
        begin
            r.digit = 6'd0;
            r.bad   = 1'b1;
        end
        return r;
    endfunction

    function automatic split_t split_byte(input logic [7:0] b);
        split_t r;
        if (b < 8'd48)
        begin
            r.cls = 3'd1;
            r.val = 6'(b);
        end
        else if (b <= 8'd57)
        begin
            r.cls = 3'd0;
            r.val = 6'(b - 8'd48);
        end
        else if (b < 8'd65)
        begin
            r.cls = 3'd1;
            r.val = 6'(b - 8'd10);
        end
        else if (b <= 8'd86)
        begin
            r.cls = 3'd0;
            r.val = 6'(b - 8'd55);
        end
        else if (b <= 8'd90)
        begin
            r.cls = 3'd4;
            r.val = 6'(b - 8'd33);
        end
        else if (b < 8'd97)
        begin
            r.cls = 3'd4;
            r.val = 6'(b - 8'd60);
        end
        else if (b <= 8'd122)
        begin
            r.cls = 3'd0;
            r.val = 6'(b - 8'd65);
        end
        else if (b <= 8'd173)
        begin
            r.cls = 3'd2;
            r.val = 6'(b - 8'd123);
        end
        else if (b <= 8'd224)
        begin
            r.cls = 3'd3;
            r.val = 6'(b - 8'd167);
        end
        else
        begin
            r.cls = 3'd4;
            r.val = 6'(b - 8'd225);
        end
        r.cls_nz = (r.cls != 3'd0);
        return r;
    endfunction

    function automatic logic [7:0] join_byte(input logic [2:0] cls, input logic [5:0] v);
        logic [7:0] r;
        unique case (cls)
            3'd0:
            begin
                if (v < 6'd10)
                    r = 8'(v) + 8'd48;
                else if (v <= 6'd31)
                    r = 8'(v) + 8'd55;
                else
                    r = 8'(v) + 8'd65;
            end
            3'd1:    r = (v < 6'd48) ? 8'(v) : 8'(v) + 8'd10;
            3'd2:    r = 8'(v) + 8'd123;
            3'd3:    r = 8'(v) + 8'd167;
            default:
            begin
                if (v < 6'd31)
                    r = 8'(v) + 8'd225;
                else if (v < 6'd37)
                    r = 8'(v) + 8'd60;
                else
                    r = 8'(v) + 8'd33;
            end
        endcase
        return r;
    endfunction

    function automatic logic [7:0] dflt_key(input logic [7:0] idx);
        logic [7:0] r;
        unique case (idx)
            8'd0:  r = 8'hbb;  8'd1:  r = 8'h65;  8'd2:  r = 8'hf6;  8'd3:  r = 8'h72;
            8'd4:  r = 8'h13;  8'd5:  r = 8'h3e;  8'd6:  r = 8'h54;  8'd7:  r = 8'h8d;
            8'd8:  r = 8'h7a;  8'd9:  r = 8'h58;  8'd10: r = 8'h47;  8'd11: r = 8'hca;
            8'd12: r = 8'hae;  8'd13: r = 8'h94;  8'd14: r = 8'h1b;  8'd15: r = 8'h98;
            8'd16: r = 8'h4e;  8'd17: r = 8'hdb;  8'd18: r = 8'h02;  8'd19: r = 8'h64;
            8'd20: r = 8'h9f;  8'd21: r = 8'h81;  8'd22: r = 8'h70;  8'd23: r = 8'h3a;
            8'd24: r = 8'h43;  8'd25: r = 8'h4c;  8'd26: r = 8'h00;  8'd27: r = 8'he4;
            8'd28: r = 8'h89;  8'd29: r = 8'h3d;  8'd30: r = 8'h39;  8'd31: r = 8'h43;
            8'd32: r = 8'h97;  8'd33: r = 8'hd0;  8'd34: r = 8'h95;  8'd35: r = 8'hc9;
            8'd36: r = 8'hac;  8'd37: r = 8'hc5;  8'd38: r = 8'h0b;  8'd39: r = 8'h29;
            8'd40: r = 8'h4f;  8'd41: r = 8'hcc;  8'd42: r = 8'ha9;  8'd43: r = 8'h7b;
            8'd44: r = 8'h1f;  8'd45: r = 8'h33;  8'd46: r = 8'hc8;  8'd47: r = 8'h0b;
            8'd48: r = 8'h89;  8'd49: r = 8'h30;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/ckc_in_if.sv
// Input channel of the cipher: valid/ready handshake with key-write and
// data-byte payload. No dependencies.
interface ckc_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [5:0] key_index;
    logic [7:0] key_byte;
    logic [7:0] data_byte;
    logic       first;

    modport source (output valid, op, key_index, key_byte, data_byte, first, input ready);
    modport sink   (input valid, op, key_index, key_byte, data_byte, first, output ready);
endinterface

>>> rtl/ckc_out_if.sv
// Result channel of the cipher: valid/ready handshake with output byte,
// last marker and error flag. No dependencies.
interface ckc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic       error;

    modport source (output valid, out_byte, out_last, error, input ready);
    modport sink   (input valid, out_byte, out_last, error, output ready);
endinterface

>>> rtl/ckc_front.sv
// Front end: accepts input items and classifies data bytes (class/value
// split or base-62 digit decode). Depends on ckc_pkg and ckc_in_if.
module ckc_front (
    ckc_in_if.sink          item,
    input  logic            mode,
    input  logic            q_full,
    output logic            q_push,
    output ckc_pkg::entry_t q_entry
);

    ckc_pkg::split_t sp;
    ckc_pkg::char_t  ch;

    assign sp = ckc_pkg::split_byte(item.data_byte);
    assign ch = ckc_pkg::from_char(item.data_byte);

    assign item.ready = !q_full;
    assign q_push     = item.valid && !q_full;

    always_comb
    begin
        q_entry.op        = item.op;
        q_entry.first     = item.first;
        q_entry.key_index = item.key_index;
        q_entry.key_byte  = item.key_byte;
        q_entry.data_byte = item.data_byte;
        if (mode == ckc_pkg::MODE_ENC)
        begin
            q_entry.cls = sp.cls;
            q_entry.val = sp.val;
            q_entry.bad = 1'b0;
        end
        else
        begin
            q_entry.cls = 3'd0;
            q_entry.val = ch.digit;
            q_entry.bad = ch.bad;
        end
    end

endmodule

>>> rtl/ckc_queue.sv
// Short item queue between front end and sequencer.
// Depends on ckc_pkg.
module ckc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ckc_pkg::entry_t push_entry,
    input  logic            pop,
    output logic            q_valid,
    output logic            q_full,
    output ckc_pkg::entry_t head
);

    localparam int                     DEPTH = ckc_pkg::QUEUE_DEPTH;
    localparam int                     PW    = ckc_pkg::QPW;
    localparam int                     CW    = ckc_pkg::QCW;
    localparam logic [PW-1:0]          LAST  = PW'(DEPTH - 1);

    ckc_pkg::entry_t entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg,  count_next;

    assign q_valid = (count_reg != '0);
    assign q_full  = (count_reg == CW'(DEPTH));
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_entry;
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("pop from empty queue");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != CW'(DEPTH)))
        else $error("push into full queue");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == CW'($past(count_reg) + 1'b1)))
        else $error("queue count did not advance on push");
`endif

endmodule

>>> rtl/ckc_back.sv
// Sequencer: key store, chain state and result emission.
// Depends on ckc_pkg and ckc_out_if.
module ckc_back #(
    parameter int KEY_DEPTH = ckc_pkg::KEY_DEPTH_DFLT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            mode,
    input  logic [6:0]      key_length,
    input  logic            q_valid,
    input  ckc_pkg::entry_t head,
    output logic            pop,
    ckc_out_if.source       result
);

    localparam int KW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int LW = $clog2(KEY_DEPTH + 1);

    ckc_pkg::back_state_t state_reg, state_next;

    logic [7:0]           key_mem [KEY_DEPTH];
    logic [KEY_DEPTH-1:0] key_vld_reg;
    logic                 mem_we;
    logic [KW-1:0]        mem_waddr;
    logic                 rd_en;
    logic [KW-1:0]        rd_addr;
    logic [7:0]           rd_data_reg;
    logic                 rd_vld_reg;
    logic [KW-1:0]        rd_addr_reg;

    logic [5:0]    prev_digit_reg,    prev_digit_next;
    logic [KW-1:0] key_pos_reg,       key_pos_next;
    logic [2:0]    pending_class_reg, pending_class_next;
    logic [1:0]    tag_count_reg,     tag_count_next;
    logic          tag_bad_reg,       tag_bad_next;

    logic       w_load;
    logic [2:0] w_cls_reg;
    logic [5:0] w_val_reg;
    logic       w_bad_reg;

    logic       out_valid_reg, out_valid_next;
    logic       out_load;
    logic [7:0] o_byte;
    logic       o_last;
    logic       o_err;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       error_reg;
    logic       slot_free;

    logic [LW-1:0] eff_len;
    logic [7:0]    kval;
    logic [5:0]    km;
    logic [5:0]    enc_x;
    logic [5:0]    enc_d;
    logic [5:0]    dec_v;
    logic [KW-1:0] c_key_pos;
    logic [KW-1:0] pos_eff;
    logic          tb_now;

    function automatic logic [KW-1:0] pos_step(input logic [KW-1:0] p,
                                               input logic [LW-1:0] len);
        logic [LW-1:0] inc;
        inc = LW'(p) + 1'b1;
        return (inc >= len) ? '0 : KW'(inc);
    endfunction

    always_comb
    begin
        if (key_length == 7'd0)
            eff_len = LW'(1);
        else if (32'(key_length) > KEY_DEPTH)
            eff_len = LW'(KEY_DEPTH);
        else
            eff_len = LW'(key_length);
    end

    assign kval  = rd_vld_reg ? rd_data_reg : ckc_pkg::dflt_key(8'(rd_addr_reg));
    assign km    = ckc_pkg::mod62(kval);
    assign enc_x = (state_reg == ckc_pkg::B_DIG && w_cls_reg != 3'd0)
                   ? 6'(w_cls_reg) + ckc_pkg::ESC_BASE : w_val_reg;
    assign enc_d = ckc_pkg::mod62(8'(enc_x) + 8'(km) + 8'(prev_digit_reg));
    assign dec_v = ckc_pkg::mod62(8'(w_val_reg) + ckc_pkg::DEC_BIAS - 8'(km)
                                  - 8'(prev_digit_reg));
    assign tb_now = tag_bad_reg | w_bad_reg;

    assign c_key_pos = head.first ? '0 : key_pos_reg;
    assign pos_eff   = (LW'(c_key_pos) >= eff_len) ? '0 : c_key_pos;

    assign slot_free = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next         = state_reg;
        prev_digit_next    = prev_digit_reg;
        key_pos_next       = key_pos_reg;
        pending_class_next = pending_class_reg;
        tag_count_next     = tag_count_reg;
        tag_bad_next       = tag_bad_reg;
        pop                = 1'b0;
        mem_we             = 1'b0;
        mem_waddr          = KW'(head.key_index);
        rd_en              = 1'b0;
        rd_addr            = pos_eff;
        w_load             = 1'b0;
        out_load           = 1'b0;
        o_byte             = 8'd0;
        o_last             = 1'b0;
        o_err              = 1'b0;

        unique case (state_reg)
            ckc_pkg::B_IDLE:
            begin
                if (q_valid)
                begin
                    pop = 1'b1;
                    if (head.op == ckc_pkg::OP_KEY)
                    begin
                        mem_we = (32'(head.key_index) < KEY_DEPTH);
                    end
                    else
                    begin
                        prev_digit_next    = head.first ? 6'd0 : prev_digit_reg;
                        pending_class_next = head.first ? 3'd0 : pending_class_reg;
                        tag_count_next     = head.first ? 2'd0 : tag_count_reg;
                        tag_bad_next       = head.first ? 1'b0 : tag_bad_reg;
                        key_pos_next       = c_key_pos;
                        if (mode == ckc_pkg::MODE_ENC)
                        begin
                            pending_class_next = 3'd0;
                            w_load             = 1'b1;
                            rd_en              = 1'b1;
                            key_pos_next       = pos_step(pos_eff, eff_len);
                            if (tag_count_next < ckc_pkg::TAG_DONE)
                            begin
                                tag_count_next = ckc_pkg::TAG_DONE;
                                state_next     = ckc_pkg::B_TAG_X;
                            end
                            else
                                state_next = ckc_pkg::B_DIG;
                        end
                        else if (tag_count_next < ckc_pkg::TAG_DONE)
                        begin
                            if (head.data_byte != ((tag_count_next == 2'd0)
                                                   ? ckc_pkg::CHAR_X : ckc_pkg::CHAR_D))
                                tag_bad_next = 1'b1;
                            tag_count_next = tag_count_next + 1'b1;
                        end
                        else
                        begin
                            w_load       = 1'b1;
                            rd_en        = 1'b1;
                            key_pos_next = pos_step(pos_eff, eff_len);
                            state_next   = ckc_pkg::B_DIG;
                        end
                    end
                end
            end
            ckc_pkg::B_TAG_X:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    o_byte     = ckc_pkg::CHAR_X;
                    state_next = ckc_pkg::B_TAG_D;
                end
            end
            ckc_pkg::B_TAG_D:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    o_byte     = ckc_pkg::CHAR_D;
                    state_next = ckc_pkg::B_DIG;
                end
            end
            ckc_pkg::B_DIG:
            begin
                if (slot_free)
                begin
                    if (mode == ckc_pkg::MODE_ENC)
                    begin
                        out_load        = 1'b1;
                        o_byte          = ckc_pkg::to_char(enc_d);
                        prev_digit_next = enc_d;
                        if (w_cls_reg != 3'd0)
                        begin
                            rd_en        = 1'b1;
                            rd_addr      = key_pos_reg;
                            key_pos_next = pos_step(key_pos_reg, eff_len);
                            state_next   = ckc_pkg::B_DIG2;
                        end
                        else
                        begin
                            o_last     = 1'b1;
                            state_next = ckc_pkg::B_IDLE;
                        end
                    end
                    else
                    begin
                        prev_digit_next = w_val_reg;
                        tag_bad_next    = tb_now;
                        state_next      = ckc_pkg::B_IDLE;
                        if (pending_class_reg == 3'd0 && dec_v > ckc_pkg::ESC_BASE)
                            pending_class_next = 3'(dec_v - ckc_pkg::ESC_BASE);
                        else
                        begin
                            out_load           = 1'b1;
                            o_byte             = ckc_pkg::join_byte(pending_class_reg, dec_v);
                            o_last             = 1'b1;
                            o_err              = tb_now;
                            pending_class_next = 3'd0;
                        end
                    end
                end
            end
            ckc_pkg::B_DIG2:
            begin
                if (slot_free)
                begin
                    out_load        = 1'b1;
                    o_byte          = ckc_pkg::to_char(enc_d);
                    o_last          = 1'b1;
                    prev_digit_next = enc_d;
                    state_next      = ckc_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = ckc_pkg::B_IDLE;
            end
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ckc_pkg::B_IDLE;
            prev_digit_reg    <= '0;
            key_pos_reg       <= '0;
            pending_class_reg <= '0;
            tag_count_reg     <= '0;
            tag_bad_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
            key_vld_reg       <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            prev_digit_reg    <= prev_digit_next;
            key_pos_reg       <= key_pos_next;
            pending_class_reg <= pending_class_next;
            tag_count_reg     <= tag_count_next;
            tag_bad_reg       <= tag_bad_next;
            out_valid_reg     <= out_valid_next;
            if (mem_we)
                key_vld_reg[mem_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            key_mem[mem_waddr] <= head.key_byte;
        if (rd_en)
        begin
            rd_data_reg <= key_mem[rd_addr];
            rd_vld_reg  <= key_vld_reg[rd_addr];
            rd_addr_reg <= rd_addr;
        end
        if (w_load)
        begin
            w_cls_reg <= head.cls;
            w_val_reg <= head.val;
            w_bad_reg <= head.bad;
        end
        if (out_load)
        begin
            out_byte_reg <= o_byte;
            out_last_reg <= o_last;
            error_reg    <= o_err;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.out_byte = out_byte_reg;
    assign result.out_last = out_last_reg;
    assign result.error    = error_reg;

`ifndef SYNTHESIS
    a_dig2_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ckc_pkg::B_DIG2) |->
            ($past(state_reg) == ckc_pkg::B_DIG || $past(state_reg) == ckc_pkg::B_DIG2))
        else $error("second digit without first digit");

    a_key_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ckc_pkg::B_IDLE) |-> (LW'(key_pos_reg) < eff_len))
        else $error("key position beyond key length");

    a_pending_range: assert property (@(posedge clk) disable iff (!rst_n)
        pending_class_reg <= 3'd4)
        else $error("escape class out of range");
`endif

endmodule

>>> rtl/keyed_base62_chained_byte_cipher_unit.sv
// Top level of the keyed base-62 chained byte cipher: configuration
// registers, front end, item queue and sequencer.
// Depends on ckc_pkg, ckc_in_if, ckc_out_if, ckc_front, ckc_queue, ckc_back.

// A key write is handled in the sequencer's idle state, as is a tag character
// in decrypt mode. A data byte first reads the key store (a memory with a
// registered read port), then forms the digit and, once the result slot is
// free, loads the output register; a decrypted escape digit only records its
// class. An encrypted byte that needs an escape digit adds a second key read
// and digit, and the first encrypted byte of a message is preceded by the "XD"
// tag. Items pass a two-entry queue, so the input keeps accepting while the
// sequencer waits on the result channel, until the queue fills. Key store
// contents follow the default key out of reset without any clearing pass.
module keyed_base62_chained_byte_cipher_unit #(
    parameter int KEY_DEPTH = ckc_pkg::KEY_DEPTH_DFLT
) (
    input  logic       clk,
    input  logic       rst_n,
    ckc_in_if.sink     item,
    ckc_out_if.source  result,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [6:0] cfg_data
);

    logic       mode_reg;
    logic [6:0] key_length_reg;

    logic            q_push;
    logic            q_pop;
    logic            q_valid;
    logic            q_full;
    ckc_pkg::entry_t q_entry;
    ckc_pkg::entry_t q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= ckc_pkg::MODE_ENC;
            key_length_reg <= 7'd50;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ckc_pkg::CFG_MODE:       mode_reg       <= cfg_data[0];
                ckc_pkg::CFG_KEY_LENGTH: key_length_reg <= cfg_data;
                default:                 mode_reg       <= mode_reg;
            endcase
        end
    end

    ckc_front u_front (
        .item    (item),
        .mode    (mode_reg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_entry)
    );

    ckc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .q_valid    (q_valid),
        .q_full     (q_full),
        .head       (q_head)
    );

    ckc_back #(
        .KEY_DEPTH (KEY_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode       (mode_reg),
        .key_length (key_length_reg),
        .q_valid    (q_valid),
        .head       (q_head),
        .pop        (q_pop),
        .result     (result)
    );

endmodule
